[hw/rtl/wcg_pkg.sv]
// Shared types and constants for the window coefficient generator.
package wcg_pkg;

    // Default sizes of the sample index and of the weight.
    localparam int unsigned WCG_INDEX_BITS  = 16;
    localparam int unsigned WCG_WEIGHT_BITS = 16;

    // Window length after reset.
    localparam int unsigned WINDOW_LENGTH_RESET = 1024;

    // Fixed-point constants of the angle path, Q2.30.
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // Weight blend factors in hundredths.
    localparam int unsigned HANN_A    = 50;
    localparam int unsigned HAMMING_A = 54;
    localparam int unsigned HAMMING_B = 46;

    // Horner steps of the cosine and sine series.
    localparam int unsigned HORNER_STEPS = 5;

    // Division by a small constant k is (p * M) >> S with M = ceil(2^S / k)
    // and S = 31 + ceil(log2 k); this is exact for every p below 2^31.
    localparam int unsigned COS_S [HORNER_STEPS] = '{38, 37, 36, 35, 32};
    localparam logic [31:0] COS_M [HORNER_STEPS] = '{
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12),
        32'(((64'd1 << 32) + 64'd1) / 64'd2)
    };
    localparam int unsigned SIN_S [HORNER_STEPS] = '{38, 38, 37, 36, 34};
    localparam logic [31:0] SIN_M [HORNER_STEPS] = '{
        32'(((64'd1 << 38) + 64'd109) / 64'd110),
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6)
    };

    // Side information of an item while its phase is being divided out.
    typedef struct packed {
        logic hamming;
        logic out_of_range;
        logic length_ok;
    } side_t;

    // Side information of an item in the angle and weight stages.
    typedef struct packed {
        logic       hamming;
        logic       out_of_range;
        logic [1:0] quadrant;
        logic       swap;
    } trig_side_t;

endpackage

[hw/rtl/window_coefficient_generator_unit.sv]
// Pipelined Hann / Hamming window coefficient generator, top level.

// The block takes one item per cycle (sample index on s_axis_tdata, window type
// on s_axis_tuser: 0 Hann, 1 Hamming) and returns one Q0.WEIGHT_BITS weight per
// item, saturated at all ones for 1.0, with an out-of-range flag in m_axis_tuser
// when the index is not below the window length. The stages are one input
// stage, INDEX_BITS restoring stages that reduce the index modulo N-1, 32
// restoring stages that form the Q0.32 turn fraction, three angle stages,
// ten Horner stages for cosine and sine in parallel, two selection stages
// and three weight stages. The whole pipeline advances together; it holds
// while the output item waits, and s_axis_tready is low only then. The window
// length register is written through cfg_valid and cfg_data, always ready,
// and must only be changed while no item is in flight.
module window_coefficient_generator_unit
    import wcg_pkg::*;
#(
    parameter int unsigned INDEX_BITS  = WCG_INDEX_BITS,
    parameter int unsigned WEIGHT_BITS = WCG_WEIGHT_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel: window length N.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [INDEX_BITS:0]                   cfg_data,
    // Input items.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((INDEX_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_index
    input  logic [0:0]                            s_axis_tuser,  // mode
    // Result items.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((WEIGHT_BITS + 7) / 8) * 8-1:0] m_axis_tdata, // weight
    output logic [0:0]                            m_axis_tuser   // index_out_of_range
);

    localparam int unsigned LEN_BITS   = INDEX_BITS + 1;
    localparam int unsigned REM_BITS   = INDEX_BITS + 2;
    localparam int unsigned OUT_DATA_W = ((WEIGHT_BITS + 7) / 8) * 8;
    localparam int unsigned FRAC_BITS  = 32;
    // Weight scaling: X = num * 2^W + 50 * 2^30, Y = X >> 32, weight = Y / 25.
    localparam int unsigned NUM_BITS   = 37;
    localparam int unsigned X_BITS     = NUM_BITS + WEIGHT_BITS;
    localparam int unsigned Y_BITS     = WEIGHT_BITS + 5;
    localparam int unsigned D25_S      = Y_BITS + 5;
    localparam int unsigned D25_MB     = Y_BITS + 1;
    localparam logic [D25_MB-1:0] D25_M =
        D25_MB'(((64'd1 << D25_S) + 64'd24) / 64'd25);
    localparam int unsigned PROD_BITS  = Y_BITS + D25_MB;

    logic                adv;
    logic [LEN_BITS-1:0] window_length_reg;
    logic [LEN_BITS-1:0] len_div;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_BITS'(WINDOW_LENGTH_RESET);
        end
        else if (cfg_valid)
        begin
            window_length_reg <= cfg_data;
        end
    end

    assign len_div = window_length_reg - LEN_BITS'(1);

    // The pipeline moves as a whole whenever the output stage can move.
    assign adv           = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------------------------------------------------------- input
    logic                  in_valid_reg;
    logic [INDEX_BITS-1:0] in_n_reg;
    side_t                 in_side_reg;
    logic [INDEX_BITS-1:0] in_n;
    side_t                 in_side_next;

    assign in_n                      = s_axis_tdata[INDEX_BITS-1:0];
    assign in_side_next.hamming      = s_axis_tuser[0];
    assign in_side_next.out_of_range = {1'b0, in_n} >= window_length_reg;
    assign in_side_next.length_ok    = |window_length_reg[LEN_BITS-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_n_reg    <= in_n;
            in_side_reg <= in_side_next;
        end
    end

    // ------------------------------------------- n mod (N-1), a bit a stage
    logic                  mod_valid_reg [INDEX_BITS];
    logic [INDEX_BITS-1:0] mod_n_reg     [INDEX_BITS];
    logic [REM_BITS-1:0]   mod_rem_reg   [INDEX_BITS];
    side_t                 mod_side_reg  [INDEX_BITS];

    for (genvar i = 0; i < INDEX_BITS; i++)
    begin : g_mod
        logic                  prev_valid;
        logic [INDEX_BITS-1:0] prev_n;
        logic [REM_BITS-1:0]   prev_rem;
        side_t                 prev_side;
        logic [REM_BITS-1:0]   trial;
        logic [REM_BITS-1:0]   rem_next;

        if (i == 0)
        begin : g_first
            assign prev_valid = in_valid_reg;
            assign prev_n     = in_n_reg;
            assign prev_rem   = '0;
            assign prev_side  = in_side_reg;
        end
        else
        begin : g_rest
            assign prev_valid = mod_valid_reg[i-1];
            assign prev_n     = mod_n_reg[i-1];
            assign prev_rem   = mod_rem_reg[i-1];
            assign prev_side  = mod_side_reg[i-1];
        end

        // Bring down the next index bit and subtract the divisor if it fits.
        assign trial    = {prev_rem[REM_BITS-2:0], prev_n[INDEX_BITS-1-i]};
        assign rem_next = (trial >= {1'b0, len_div}) ? trial - {1'b0, len_div} : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mod_valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                mod_valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mod_n_reg[i]    <= prev_n;
                mod_rem_reg[i]  <= rem_next;
                mod_side_reg[i] <= prev_side;
            end
        end
    end

    // ----------------------- turn fraction (rem * 2^32) / (N-1), a bit a stage
    logic                 frac_valid_reg [FRAC_BITS];
    logic [REM_BITS-1:0]  frac_rem_reg   [FRAC_BITS];
    logic [FRAC_BITS-1:0] frac_q_reg     [FRAC_BITS];
    side_t                frac_side_reg  [FRAC_BITS];

    for (genvar j = 0; j < FRAC_BITS; j++)
    begin : g_frac
        logic                 prev_valid;
        logic [REM_BITS-1:0]  prev_rem;
        logic [FRAC_BITS-1:0] prev_q;
        side_t                prev_side;
        logic [REM_BITS-1:0]  trial;
        logic                 fits;

        if (j == 0)
        begin : g_first
            assign prev_valid = mod_valid_reg[INDEX_BITS-1];
            assign prev_rem   = mod_rem_reg[INDEX_BITS-1];
            assign prev_q     = '0;
            assign prev_side  = mod_side_reg[INDEX_BITS-1];
        end
        else
        begin : g_rest
            assign prev_valid = frac_valid_reg[j-1];
            assign prev_rem   = frac_rem_reg[j-1];
            assign prev_q     = frac_q_reg[j-1];
            assign prev_side  = frac_side_reg[j-1];
        end

        assign trial = {prev_rem[REM_BITS-2:0], 1'b0};
        assign fits  = trial >= {1'b0, len_div};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                frac_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                frac_valid_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                frac_rem_reg[j]  <= fits ? trial - {1'b0, len_div} : trial;
                frac_q_reg[j]    <= {prev_q[FRAC_BITS-2:0], fits};
                frac_side_reg[j] <= prev_side;
            end
        end
    end

    // ------------------------------------------ fold the turn into an octant
    logic                 fold_valid_reg;
    logic [29:0]          fold_ra_reg;
    trig_side_t           fold_side_reg;
    logic [FRAC_BITS-1:0] turn;
    logic [29:0]          turn_rest;
    trig_side_t           fold_side_next;

    // A window shorter than two samples has phase zero.
    assign turn      = frac_side_reg[FRAC_BITS-1].length_ok ? frac_q_reg[FRAC_BITS-1] : '0;
    assign turn_rest = turn[29:0];

    assign fold_side_next.hamming      = frac_side_reg[FRAC_BITS-1].hamming;
    assign fold_side_next.out_of_range = frac_side_reg[FRAC_BITS-1].out_of_range;
    assign fold_side_next.quadrant     = turn[31:30];
    assign fold_side_next.swap         = turn_rest > 30'h2000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fold_valid_reg <= frac_valid_reg[FRAC_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_ra_reg   <= fold_side_next.swap ? 30'(ONE_Q30 - {1'b0, turn_rest}) : turn_rest;
            fold_side_reg <= fold_side_next;
        end
    end

    // ------------------------------------------------ octant angle in Q2.30
    logic        xang_valid_reg;
    logic [29:0] xang_x_reg;
    trig_side_t  xang_side_reg;
    logic [61:0] xang_prod;

    assign xang_prod = fold_ra_reg * PI_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xang_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            xang_valid_reg <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xang_x_reg    <= xang_prod[60:31];
            xang_side_reg <= fold_side_reg;
        end
    end

    // ------------------------------------------------------ square of angle
    logic        xsq_valid_reg;
    logic [29:0] xsq_x_reg;
    logic [29:0] xsq_x2_reg;
    trig_side_t  xsq_side_reg;
    logic [59:0] xsq_prod;

    assign xsq_prod = xang_x_reg * xang_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xsq_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            xsq_valid_reg <= xang_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xsq_x_reg    <= xang_x_reg;
            xsq_x2_reg   <= xsq_prod[59:30];
            xsq_side_reg <= xang_side_reg;
        end
    end

    // ------------------------- Horner steps: t = 1 - ((x2 * t) >> 30) / k
    logic        hm_mul_valid_reg [HORNER_STEPS];
    logic [29:0] hm_mul_x_reg     [HORNER_STEPS];
    logic [29:0] hm_mul_x2_reg    [HORNER_STEPS];
    logic [29:0] hm_pc_reg        [HORNER_STEPS];
    logic [29:0] hm_ps_reg        [HORNER_STEPS];
    trig_side_t  hm_mul_side_reg  [HORNER_STEPS];
    logic        hm_div_valid_reg [HORNER_STEPS];
    logic [29:0] hm_div_x_reg     [HORNER_STEPS];
    logic [29:0] hm_div_x2_reg    [HORNER_STEPS];
    logic [30:0] hm_tc_reg        [HORNER_STEPS];
    logic [30:0] hm_ts_reg        [HORNER_STEPS];
    trig_side_t  hm_div_side_reg  [HORNER_STEPS];

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        logic        prev_valid;
        logic [29:0] prev_x;
        logic [29:0] prev_x2;
        logic [30:0] prev_tc;
        logic [30:0] prev_ts;
        trig_side_t  prev_side;
        logic [60:0] mul_c;
        logic [60:0] mul_s;
        logic [61:0] div_c;
        logic [61:0] div_s;
        logic [29:0] quo_c;
        logic [29:0] quo_s;

        if (k == 0)
        begin : g_first
            assign prev_valid = xsq_valid_reg;
            assign prev_x     = xsq_x_reg;
            assign prev_x2    = xsq_x2_reg;
            assign prev_tc    = ONE_Q30;
            assign prev_ts    = ONE_Q30;
            assign prev_side  = xsq_side_reg;
        end
        else
        begin : g_rest
            assign prev_valid = hm_div_valid_reg[k-1];
            assign prev_x     = hm_div_x_reg[k-1];
            assign prev_x2    = hm_div_x2_reg[k-1];
            assign prev_tc    = hm_tc_reg[k-1];
            assign prev_ts    = hm_ts_reg[k-1];
            assign prev_side  = hm_div_side_reg[k-1];
        end

        // Product stage.
        assign mul_c = prev_x2 * prev_tc;
        assign mul_s = prev_x2 * prev_ts;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hm_mul_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                hm_mul_valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hm_mul_x_reg[k]    <= prev_x;
                hm_mul_x2_reg[k]   <= prev_x2;
                hm_pc_reg[k]       <= mul_c[59:30];
                hm_ps_reg[k]       <= mul_s[59:30];
                hm_mul_side_reg[k] <= prev_side;
            end
        end

        // Constant division by reciprocal, then subtract from one.
        assign div_c = hm_pc_reg[k] * COS_M[k];
        assign div_s = hm_ps_reg[k] * SIN_M[k];
        assign quo_c = 30'(div_c >> COS_S[k]);
        assign quo_s = 30'(div_s >> SIN_S[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hm_div_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                hm_div_valid_reg[k] <= hm_mul_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hm_div_x_reg[k]    <= hm_mul_x_reg[k];
                hm_div_x2_reg[k]   <= hm_mul_x2_reg[k];
                hm_tc_reg[k]       <= ONE_Q30 - {1'b0, quo_c};
                hm_ts_reg[k]       <= ONE_Q30 - {1'b0, quo_s};
                hm_div_side_reg[k] <= hm_mul_side_reg[k];
            end
        end
    end

    // ------------------------------------- finish sine with its factor of x
    logic        tri_valid_reg;
    logic [30:0] tri_cos_reg;
    logic [29:0] tri_sin_reg;
    trig_side_t  tri_side_reg;
    logic [60:0] tri_prod;

    assign tri_prod = hm_div_x_reg[HORNER_STEPS-1] * hm_ts_reg[HORNER_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tri_valid_reg <= hm_div_valid_reg[HORNER_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tri_cos_reg  <= hm_tc_reg[HORNER_STEPS-1];
            tri_sin_reg  <= tri_prod[59:30];
            tri_side_reg <= hm_div_side_reg[HORNER_STEPS-1];
        end
    end

    // ------------------------------- cosine of the full turn: magnitude, sign
    logic        mag_valid_reg;
    logic [30:0] mag_m_reg;
    logic        mag_neg_reg;
    logic        mag_hamming_reg;
    logic        mag_oor_reg;
    logic [30:0] oct_c;
    logic [30:0] oct_s;
    logic [30:0] mag_m_next;
    logic        mag_neg_next;

    assign oct_c = tri_side_reg.swap ? {1'b0, tri_sin_reg} : tri_cos_reg;
    assign oct_s = tri_side_reg.swap ? tri_cos_reg : {1'b0, tri_sin_reg};

    always_comb
    begin
        case (tri_side_reg.quadrant)
            2'd0:
            begin
                mag_m_next   = oct_c;
                mag_neg_next = 1'b0;
            end
            2'd1:
            begin
                mag_m_next   = oct_s;
                mag_neg_next = 1'b1;
            end
            2'd2:
            begin
                mag_m_next   = oct_c;
                mag_neg_next = 1'b1;
            end
            default:
            begin
                mag_m_next   = oct_s;
                mag_neg_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mag_valid_reg <= tri_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_m_reg       <= mag_m_next;
            mag_neg_reg     <= mag_neg_next;
            mag_hamming_reg <= tri_side_reg.hamming;
            mag_oor_reg     <= tri_side_reg.out_of_range;
        end
    end

    // ------------------------------------- blend numerator in hundredths, Q30
    logic                num_valid_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic                num_oor_reg;
    logic [NUM_BITS-1:0] mag_wide;
    logic [NUM_BITS-1:0] one_wide;
    logic [NUM_BITS-1:0] num_next;

    assign mag_wide = NUM_BITS'(mag_m_reg);
    assign one_wide = NUM_BITS'(ONE_Q30);

    always_comb
    begin
        if (mag_hamming_reg)
        begin
            num_next = mag_neg_reg
                ? NUM_BITS'(HAMMING_A) * one_wide + NUM_BITS'(HAMMING_B) * mag_wide
                : NUM_BITS'(HAMMING_A) * one_wide - NUM_BITS'(HAMMING_B) * mag_wide;
        end
        else
        begin
            num_next = mag_neg_reg
                ? NUM_BITS'(HANN_A) * (one_wide + mag_wide)
                : NUM_BITS'(HANN_A) * (one_wide - mag_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            num_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg     <= num_next;
            num_oor_reg <= mag_oor_reg;
        end
    end

    // ---------------------- scale with rounding, then divide by 25 by reciprocal
    logic                 scl_valid_reg;
    logic [PROD_BITS-1:0] scl_prod_reg;
    logic                 scl_oor_reg;
    logic [X_BITS-1:0]    scl_x;
    logic [Y_BITS-1:0]    scl_y;

    assign scl_x = {num_reg, {WEIGHT_BITS{1'b0}}} + X_BITS'(64'd50 << 30);
    assign scl_y = scl_x[X_BITS-1:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            scl_valid_reg <= num_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scl_prod_reg <= scl_y * D25_M;
            scl_oor_reg  <= num_oor_reg;
        end
    end

    // --------------------------------------------- saturate into the output
    logic                   out_valid_reg;
    logic [WEIGHT_BITS-1:0] out_weight_reg;
    logic                   out_oor_reg;
    logic [WEIGHT_BITS:0]   out_quo;

    assign out_quo = scl_prod_reg[PROD_BITS-1:D25_S];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= scl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_weight_reg <= out_quo[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}}
                                                   : out_quo[WEIGHT_BITS-1:0];
            out_oor_reg    <= scl_oor_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_DATA_W'(out_weight_reg);
    assign m_axis_tuser[0] = out_oor_reg;

endmodule

[dv/window_coefficient_generator_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Hann / Hamming window coefficient generator.
module window_coefficient_generator_unit_tb
    import wcg_pkg::*;
();

    localparam int unsigned IDX_W = WCG_INDEX_BITS;
    localparam int unsigned WGT_W = WCG_WEIGHT_BITS;
    localparam int unsigned PIPE_LATENCY = IDX_W + 51;

    // Expected outcome of one item.
    typedef struct {
        bit [WGT_W-1:0] weight;
        bit             out_of_range;
    } window_weight_t;

    // Holds the window length seen by the block and the weights still owed by it.
    class window_weight_scoreboard;
        bit [IDX_W:0]   window_length;
        window_weight_t owed_weights[$];
        int             error_count;

        function new();
            window_length = (IDX_W + 1)'(WINDOW_LENGTH_RESET);
            error_count   = 0;
        endfunction

        // Truncated Taylor series of cos(x), x in Q2.30 within one octant.
        function bit [63:0] octant_cos(bit [63:0] x);
            bit [63:0] one, x2, t;
            one = 64'd1 << 30;
            x2 = (x * x) >> 30;
            t  = one - x2 / 90;
            t  = one - ((x2 * t) >> 30) / 56;
            t  = one - ((x2 * t) >> 30) / 30;
            t  = one - ((x2 * t) >> 30) / 12;
            return one - ((x2 * t) >> 30) / 2;
        endfunction

        // Truncated Taylor series of sin(x), x in Q2.30 within one octant.
        function bit [63:0] octant_sin(bit [63:0] x);
            bit [63:0] one, x2, t;
            one = 64'd1 << 30;
            x2 = (x * x) >> 30;
            t  = one - x2 / 110;
            t  = one - ((x2 * t) >> 30) / 72;
            t  = one - ((x2 * t) >> 30) / 42;
            t  = one - ((x2 * t) >> 30) / 20;
            t  = one - ((x2 * t) >> 30) / 6;
            return (x * t) >> 30;
        endfunction

        // Weight and range flag for one sample index under the current length.
        function window_weight_t compute_weight(bit [IDX_W-1:0] sample_index, bit hamming);
            window_weight_t res;
            bit [63:0] one, pi_q30, n, d, turn, frac, x, c, s, mag, num, w;
            bit        neg;
            one    = 64'd1 << 30;
            pi_q30 = 64'd3373259426;
            n      = 64'(sample_index);
            turn   = 64'd0;
            if (window_length >= 2)
            begin
                d    = 64'(window_length) - 64'd1;
                turn = ((n % d) << 32) / d;
            end
            // Fold the quarter turn into an octant angle.
            frac = turn & (one - 64'd1);
            if (frac <= (one >> 1))
            begin
                x = (frac * pi_q30) >> 31;
                c = octant_cos(x);
                s = octant_sin(x);
            end
            else
            begin
                x = ((one - frac) * pi_q30) >> 31;
                c = octant_sin(x);
                s = octant_cos(x);
            end
            case (turn[31:30])
                2'd0:    begin neg = 1'b0; mag = c; end
                2'd1:    begin neg = 1'b1; mag = s; end
                2'd2:    begin neg = 1'b1; mag = c; end
                default: begin neg = 1'b0; mag = s; end
            endcase
            // Blend in hundredths, then round to the output format.
            if (hamming)
                num = neg ? (64'd54 * one + 64'd46 * mag) : (64'd54 * one - 64'd46 * mag);
            else
                num = neg ? (64'd50 * (one + mag)) : (64'd50 * (one - mag));
            w = ((num << WGT_W) + 64'd50 * one) / (64'd100 * one);
            if (w > ((64'd1 << WGT_W) - 64'd1))
                w = (64'd1 << WGT_W) - 64'd1;
            res.weight       = w[WGT_W-1:0];
            res.out_of_range = (64'(sample_index) >= 64'(window_length));
            return res;
        endfunction

        function void note_input(bit [IDX_W-1:0] sample_index, bit hamming);
            owed_weights.push_back(compute_weight(sample_index, hamming));
        endfunction

        function void check_result(bit [WGT_W-1:0] weight, bit out_of_range);
            window_weight_t exp_res;
            if (owed_weights.size() == 0)
            begin
                $display("%0t: unexpected item, weight %0d flag %0b", $time, weight,
                         out_of_range);
                error_count++;
                return;
            end
            exp_res = owed_weights.pop_front();
            if (exp_res.weight !== weight)
            begin
                $display("%0t: weight mismatch, expected %0d actual %0d", $time,
                         exp_res.weight, weight);
                error_count++;
            end
            if (exp_res.out_of_range !== out_of_range)
            begin
                $display("%0t: range flag mismatch, expected %0b actual %0b", $time,
                         exp_res.out_of_range, out_of_range);
                error_count++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [IDX_W:0]                    cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [((IDX_W + 7) / 8) * 8-1:0]  s_axis_tdata = '0;  // sample_index
    logic [0:0]                        s_axis_tuser = '0;  // mode
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [((WGT_W + 7) / 8) * 8-1:0]  m_axis_tdata;       // weight
    logic [0:0]                        m_axis_tuser;       // index_out_of_range

    window_weight_scoreboard sb;
    bit                      no_idle = 1'b0;

    window_coefficient_generator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sample index for the random part, biased toward the window and its edges.
    function automatic bit [IDX_W-1:0] pick_index(bit [IDX_W:0] len);
        int unsigned sel, top, lim;
        sel = $urandom_range(0, 99);
        top = (len == 0) ? 0 : ((len > 65536) ? 65535 : int'(len) - 1);
        lim = (len > 65535) ? 65535 : int'(len);
        if (sel < 70)
            return IDX_W'($urandom_range(0, top));
        if (sel < 82)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return IDX_W'(top);
                2:       return IDX_W'(lim);
                3:       return IDX_W'(top / 2);
                default: return IDX_W'((top / 4) * 3);
            endcase
        end
        return IDX_W'($urandom());
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input bit [IDX_W-1:0] sample_index, input bit hamming);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_index;
        s_axis_tuser  <= hamming;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(sample_index, hamming);
    endtask

    task automatic write_window_length(input bit [IDX_W:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.window_length = value;
    endtask

    // Stop offering and let every owed weight come out.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_weights.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result side: check every accepted item, stall at random, and hold off
    // for a long stretch twice so that the pipeline fills and blocks its input.
    initial
    begin
        int stall_left;
        int results_seen;
        stall_left   = 0;
        results_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata[WGT_W-1:0], m_axis_tuser[0]);
                results_seen++;
                if (results_seen == 150 || results_seen == 700)
                    stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        bit [IDX_W-1:0] corner_idx [11];
        bit [IDX_W:0]   lengths [11];
        int             ph;
        int             k;
        sb = new();
        corner_idx = '{0, 1, 128, 256, 384, 511, 640, 767, 1022, 1023, 1024};
        lengths    = '{2, 65536, 0, 1, 131071, 3, 65535, 0, 0, 0, 1024};
        lengths[7] = (IDX_W + 1)'($urandom());
        lengths[8] = (IDX_W + 1)'($urandom_range(4, 4096));
        lengths[9] = (IDX_W + 1)'($urandom_range(2, 300));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset length: both window types at the start,
        // the end and the quarter points of the window, the wrap at N-1,
        // the first index past the window and the largest index.
        foreach (corner_idx[i])
        begin
            send_item(corner_idx[i], 1'b0);
            send_item(corner_idx[i], 1'b1);
        end
        send_item('1, 1'b0);
        send_item('1, 1'b1);
        for (k = 0; k < 100; k++)
            send_item(pick_index(sb.window_length), 1'($urandom()));
        drain_pipeline();

        // Random phases over a range of window lengths, extremes included.
        for (ph = 0; ph < 11; ph++)
        begin
            no_idle = (ph == 2);
            write_window_length(lengths[ph]);
            @(posedge clk);
            for (k = 0; k < 90; k++)
                send_item(pick_index(sb.window_length), 1'($urandom()));
            drain_pipeline();
        end
        no_idle = 1'b0;

        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (sb.error_count == 0 && sb.owed_weights.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hw/rtl/wcg_pkg.sv
hw/rtl/window_coefficient_generator_unit.sv
dv/window_coefficient_generator_unit_tb.sv
